// ===== sv/lsg_pkg.sv =====
// Shared types, constants and arithmetic helpers for the LED status effect generator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lsg_pkg;

  // Mode codes, same encoding as the robot state input
  localparam logic [1:0] MODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_THINKING = 2'd1;
  localparam logic [1:0] MODE_SPEAKING = 2'd2;
  localparam logic [1:0] MODE_ERROR    = 2'd3;

  localparam int unsigned LED_COUNT_DEFAULT = 16;
  localparam int unsigned LED_COUNT_MAX     = 64;
  localparam int unsigned TICK_FIFO_DEPTH   = 2;

  // Idle breath: triangle of period 40 and peak 45; slope 2*45/40 reduces to 9/4 exactly
  localparam int unsigned IDLE_PERIOD      = 40;
  localparam int unsigned IDLE_HALF        = IDLE_PERIOD / 2;
  localparam int unsigned IDLE_SLOPE_NUM   = 9;
  localparam int unsigned IDLE_SLOPE_SHIFT = 2;

  // Thinking breath: period 16, peak 80; slope 2*80/16 is a whole number
  localparam int unsigned THINK_PERIOD = 16;
  localparam int unsigned THINK_HALF   = THINK_PERIOD / 2;
  localparam int unsigned THINK_PEAK   = 80;
  localparam int unsigned THINK_SLOPE  = 2 * THINK_PEAK / THINK_PERIOD;
  localparam int unsigned THINK_GREEN  = 55;

  localparam int unsigned ERROR_RED = 100;

  // Rainbow: hue advances 9 degrees per tick, computed on a 32-bit product that wraps
  localparam int unsigned HUE_FULL      = 360;
  localparam int unsigned HUE_TICK_STEP = 9;
  localparam int unsigned HUE_WRAP_REM  = int'((64'd1 << 32) % 64'd360);
  // Hue increment on the tick where the 32-bit product wraps
  localparam int unsigned HUE_WRAP_STEP = HUE_TICK_STEP + HUE_FULL - HUE_WRAP_REM;
  localparam int unsigned HUE_SECTOR    = 60;
  localparam int unsigned HSV_VALUE     = 70;
  localparam int unsigned FRAC_MAX      = 255;

  typedef struct packed {
    logic [1:0]  robot_mode;
    logic        request_write;
    logic [1:0]  request_mode;
    logic        force_write;
    logic [1:0]  force_mode;
    logic [15:0] force_count;
  } in_item_t;

  typedef struct packed {
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] shown_mode;
    logic       last_pixel;
  } out_item_t;

  // One frame tick as handed from the front to the pixel sequencer
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [8:0] hue_base;
  } tick_desc_t;

  // floor(x / 255) for x below 2^15: reciprocal multiply and one correction
  function automatic logic [7:0] div255(input logic [14:0] x);
    logic [23:0] prod;
    logic [7:0]  quo;
    logic [15:0] rem;
    prod = 24'(x) * 24'd257;
    quo  = 8'(prod >> 16);
    rem  = 16'(x) - 16'(quo) * 16'(FRAC_MAX);
    if (rem >= 16'(FRAC_MAX)) begin
      quo = quo + 8'd1;
    end
    return quo;
  endfunction

endpackage

// ===== sv/led_status_effect_generator_unit.sv =====
// Top level of the LED status effect generator: front end, tick queue, pixel back end.
// Depends on lsg_pkg, lsg_front, lsg_tick_fifo and lsg_back.
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// ticks    in         push / full            in_item_i  (in_item_t), one frame tick
// pixels   out        empty / pop            out_item_o (out_item_t), one LED color
//
// A tick is taken whenever the tick queue has room; its writes,
// mode pick and color descriptor are settled in the cycle it is taken.
// The pixel sequencer emits one pixel per cycle while the output register is free or popped;
// the first pixel of a tick passes the queue, then the s1, s2 and output registers.
// Reset clears the tick counter, pending request, force state and all valid bits.
// A stalled pop freezes the pixel pipeline only; the front takes ticks until the queue fills.

module led_status_effect_generator_unit
  import lsg_pkg::*;
#(
  parameter int unsigned LED_COUNT  = LED_COUNT_DEFAULT,
  parameter int unsigned TICK_DEPTH = TICK_FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item_i,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item_o
);

  // Front to queue
  logic       wr_en;
  tick_desc_t wr_desc;
  // Queue to back
  tick_desc_t rd_desc;
  logic       fifo_full, fifo_empty, fifo_pop;
  logic       out_valid;

  lsg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .fifo_full_i (fifo_full),
    .wr_en_o     (wr_en),
    .desc_o      (wr_desc)
  );

  lsg_tick_fifo #(
    .Depth (TICK_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_desc),
    .rd_en_i   (fifo_pop),
    .rd_data_o (rd_desc),
    .full_o    (fifo_full),
    .empty_o   (fifo_empty)
  );

  // Back end holds the queue head until the last pixel of the tick is issued
  lsg_back #(
    .LedCount (LED_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .desc_i       (rd_desc),
    .fifo_pop_o   (fifo_pop),
    .pop_i        (pop),
    .out_valid_o  (out_valid),
    .out_item_o   (out_item_o)
  );

  assign full  = fifo_full;
  assign empty = !out_valid;

endmodule

// ===== sv/lsg_front.sv =====
// Front end: accepts frame ticks, applies request/force writes, picks the mode
// and builds the per-tick color descriptor. Depends on lsg_pkg.
`timescale 1ns / 1ps

module lsg_front
  import lsg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  in_item_t   item_i,
  input  logic       fifo_full_i,
  output logic       wr_en_o,
  output tick_desc_t desc_o
);

  logic [31:0] tick_q, tick_d;
  logic [31:0] acc9_q, acc9_d;
  logic [5:0]  ph40_q, ph40_d;
  logic [8:0]  hue_q, hue_d;
  logic [1:0]  pend_q, pend_d;
  logic [1:0]  forced_q, forced_d;
  logic [15:0] remain_q, remain_d;

  logic        accept;
  logic [1:0]  pend_w;
  logic [15:0] remain_w;
  logic [1:0]  mode;
  logic        acc_carry;
  logic [9:0]  hue_sum;
  logic [5:0]  idle_tri;
  logic [7:0]  idle_b;
  logic [3:0]  ph16;
  logic [4:0]  think_tri;
  logic [7:0]  think_b;

  assign accept  = push_i && !fifo_full_i;
  assign wr_en_o = accept;

  // Writes land before the mode pick of the same tick
  always_comb begin
    pend_w   = item_i.request_write ? item_i.request_mode : pend_q;
    forced_d = item_i.force_write ? item_i.force_mode : forced_q;
    remain_w = item_i.force_write ? item_i.force_count : remain_q;
    pend_d   = pend_w;
    remain_d = remain_w;
    if (remain_w != 16'd0) begin
      mode     = forced_d;
      remain_d = remain_w - 16'd1;
    end else if (pend_w != MODE_IDLE) begin
      mode   = pend_w;
      pend_d = MODE_IDLE;
    end else begin
      mode = item_i.robot_mode;
    end
  end

  // Tick-derived phases, kept incrementally
  always_comb begin
    tick_d             = tick_q + 32'd1;
    {acc_carry, acc9_d} = {1'b0, acc9_q} + 33'(HUE_TICK_STEP);
    hue_sum            = 10'(hue_q) + (acc_carry ? 10'(HUE_WRAP_STEP) : 10'(HUE_TICK_STEP));
    if (hue_sum >= 10'(HUE_FULL)) begin
      hue_d = 9'(hue_sum - 10'(HUE_FULL));
    end else begin
      hue_d = 9'(hue_sum);
    end
    if (tick_q == '1 || ph40_q == 6'(IDLE_PERIOD - 1)) begin
      ph40_d = 6'd0;
    end else begin
      ph40_d = ph40_q + 6'd1;
    end
  end

  always_comb begin
    idle_tri  = (ph40_q < 6'(IDLE_HALF)) ? ph40_q : 6'(IDLE_PERIOD) - ph40_q;
    idle_b    = 8'((10'(idle_tri) * 10'(IDLE_SLOPE_NUM)) >> IDLE_SLOPE_SHIFT);
    ph16      = tick_q[3:0];
    think_tri = (ph16 < 4'(THINK_HALF)) ? 5'(ph16) : 5'(THINK_PERIOD) - 5'(ph16);
    think_b   = 8'(think_tri) * 8'(THINK_SLOPE);

    desc_o.mode     = mode;
    desc_o.hue_base = hue_q;
    desc_o.red      = 8'd0;
    desc_o.green    = 8'd0;
    desc_o.blue     = 8'd0;
    case (mode)
      MODE_IDLE: begin
        desc_o.green = idle_b >> 2;
        desc_o.blue  = idle_b;
      end
      MODE_THINKING: begin
        desc_o.red   = think_b;
        desc_o.green = 8'(THINK_GREEN);
      end
      MODE_ERROR: begin
        desc_o.red = tick_q[1] ? 8'd0 : 8'(ERROR_RED);
      end
      default: begin
        // speaking: color comes from hue in the back end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      acc9_q   <= '0;
      ph40_q   <= '0;
      hue_q    <= '0;
      pend_q   <= MODE_IDLE;
      forced_q <= MODE_IDLE;
      remain_q <= '0;
    end else if (accept) begin
      tick_q   <= tick_d;
      acc9_q   <= acc9_d;
      ph40_q   <= ph40_d;
      hue_q    <= hue_d;
      pend_q   <= pend_d;
      forced_q <= forced_d;
      remain_q <= remain_d;
    end
  end

endmodule

// ===== sv/lsg_tick_fifo.sv =====
// Short queue of tick descriptors between front and back end.
// Depends on lsg_pkg.
`timescale 1ns / 1ps

module lsg_tick_fifo
  import lsg_pkg::*;
#(
  parameter int unsigned Depth = TICK_FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  tick_desc_t wr_data_i,
  input  logic       rd_en_i,
  output tick_desc_t rd_data_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tick_desc_t          mem_q [Depth];
  logic [PtrW-1:0]     wptr_q, wptr_d;
  logic [PtrW-1:0]     rptr_q, rptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

// ===== sv/lsg_back.sv =====
// Back end: walks the LEDs of one tick, one pixel per cycle while not stalled,
// through a three-register pipeline (hue, sector/fraction, output). Depends on lsg_pkg.
`timescale 1ns / 1ps

module lsg_back
  import lsg_pkg::*;
#(
  parameter int unsigned LedCount = LED_COUNT_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fifo_empty_i,
  input  tick_desc_t desc_i,
  output logic       fifo_pop_o,
  input  logic       pop_i,
  output logic       out_valid_o,
  output out_item_t  out_item_o
);

  localparam int unsigned PixW    = (LedCount > 1) ? $clog2(LedCount) : 1;
  localparam int unsigned HueStep = HUE_FULL / LedCount;

  typedef struct packed {
    logic [5:0] pix;
    logic       last;
    logic [1:0] mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_info_t;

  logic            en, issue, is_last;
  logic [PixW-1:0] pix_q, pix_d;
  logic [8:0]      hue_run_q, hue_run_d;
  logic [8:0]      hue_cur;
  logic [9:0]      hue_sum;

  logic            s1_v_q, s2_v_q, out_v_q;
  pix_info_t       s1_q, s2_q;
  logic [8:0]      s1_hue_q;
  logic [2:0]      s2_sector_q;
  logic [7:0]      s2_frac_q;
  out_item_t       out_q, out_d;

  logic [2:0]      sector;
  logic [8:0]      sector_base;
  logic [5:0]      hue_mod;
  logic [7:0]      frac;
  logic [7:0]      rise, fall, hv;

  // Whole pipeline moves when the output register is free or being taken
  assign en         = !out_v_q || pop_i;
  assign issue      = en && !fifo_empty_i;
  assign is_last    = (pix_q == PixW'(LedCount - 1));
  assign fifo_pop_o = issue && is_last;

  always_comb begin
    hue_cur = (pix_q == '0) ? desc_i.hue_base : hue_run_q;
    hue_sum = 10'(hue_cur) + 10'(HueStep);
    if (hue_sum >= 10'(HUE_FULL)) begin
      hue_run_d = 9'(hue_sum - 10'(HUE_FULL));
    end else begin
      hue_run_d = 9'(hue_sum);
    end
    pix_d = is_last ? '0 : pix_q + 1'b1;
  end

  // Sector and fraction within the sector; (m*255)/60 is m*17/4 exactly
  always_comb begin
    if (s1_hue_q >= 9'(5 * HUE_SECTOR)) begin
      sector = 3'd5;
    end else if (s1_hue_q >= 9'(4 * HUE_SECTOR)) begin
      sector = 3'd4;
    end else if (s1_hue_q >= 9'(3 * HUE_SECTOR)) begin
      sector = 3'd3;
    end else if (s1_hue_q >= 9'(2 * HUE_SECTOR)) begin
      sector = 3'd2;
    end else if (s1_hue_q >= 9'(HUE_SECTOR)) begin
      sector = 3'd1;
    end else begin
      sector = 3'd0;
    end
    sector_base = 9'(sector) * 9'(HUE_SECTOR);
    hue_mod     = 6'(s1_hue_q - sector_base);
    frac        = 8'((10'(hue_mod) * 10'd17) >> 2);
  end

  always_comb begin
    rise = div255(15'(15'(s2_frac_q) * 15'(HSV_VALUE)));
    fall = div255(15'(15'(8'(FRAC_MAX) - s2_frac_q) * 15'(HSV_VALUE)));
    hv   = 8'(HSV_VALUE);

    out_d.pixel_index = s2_q.pix;
    out_d.shown_mode  = s2_q.mode;
    out_d.last_pixel  = s2_q.last;
    out_d.red         = s2_q.red;
    out_d.green       = s2_q.green;
    out_d.blue        = s2_q.blue;
    if (s2_q.mode == MODE_SPEAKING) begin
      case (s2_sector_q)
        3'd0: begin
          out_d.red = hv;   out_d.green = rise; out_d.blue = 8'd0;
        end
        3'd1: begin
          out_d.red = fall; out_d.green = hv;   out_d.blue = 8'd0;
        end
        3'd2: begin
          out_d.red = 8'd0; out_d.green = hv;   out_d.blue = rise;
        end
        3'd3: begin
          out_d.red = 8'd0; out_d.green = fall; out_d.blue = hv;
        end
        3'd4: begin
          out_d.red = rise; out_d.green = 8'd0; out_d.blue = hv;
        end
        default: begin
          out_d.red = hv;   out_d.green = 8'd0; out_d.blue = fall;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q   <= '0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= issue;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
      if (issue) begin
        pix_q <= pix_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (issue) begin
        hue_run_q     <= hue_run_d;
        s1_hue_q      <= hue_cur;
        s1_q.pix      <= 6'(pix_q);
        s1_q.last     <= is_last;
        s1_q.mode     <= desc_i.mode;
        s1_q.red      <= desc_i.red;
        s1_q.green    <= desc_i.green;
        s1_q.blue     <= desc_i.blue;
      end
      s2_q        <= s1_q;
      s2_sector_q <= sector;
      s2_frac_q   <= frac;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule
